>>> design/lhte_pkg.sv
// Package for the linear hash table engine: status codes and hash constants.
// No dependencies.
`default_nettype none
package lhte_pkg;
  localparam logic [1:0] StFound    = 2'd0;
  localparam logic [1:0] StInserted = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;
  localparam int unsigned HashSeed  = 5381;
  localparam logic       CmdInsert  = 1'b1;
endpackage
`default_nettype wire

>>> design/lhte_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface lhte_if #(parameter int W = 8) (input wire logic clk_i);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/linear_hash_table_engine_top.sv
// Top level of the linear hash table engine: front hasher, queue, back walker.
// Depends on lhte_pkg, lhte_if, lhte_front, lhte_back, lhte_ram.
//
//  channel  dir  payload                               handshake
//  in_if    in   command, key_bytes, key_length        valid/ready
//  out_if   out  status, entry_index, element_count    valid/ready
//
// Front: one hash step a cycle, one step per key byte, then a push to the queue.
// Back: reads the bin head, then compares each chain link visited; a miss goes
// on to the insert state, and an insert that grows the table splits one bin.
// After reset every slot of the bin-head RAM is cleared; no request
// is taken then. A stalled result holds in the output register.
`default_nettype none
module linear_hash_table_engine_top #(
  parameter int ENTRY_CAPACITY = 256,
  parameter int BIN_SLOTS      = 512,
  parameter int KEY_BYTES_MAX  = 8,
  parameter int HASH_WIDTH     = 32
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  lhte_if.sink     in_if,
  lhte_if.source   out_if
);
  localparam int QW = HASH_WIDTH + 69;
  logic          qv, qr, clr, frdy;
  logic [QW-1:0] qd;
  logic [1:0]    st;
  logic [7:0]    ix;
  logic [8:0]    cnt;

  // no request is taken while the bin heads are being cleared
  assign in_if.ready = frdy && !clr;

  lhte_front #(.HW(HASH_WIDTH), .QW(QW)) u_front (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid && !clr), .in_ready_o(frdy),
    .cmd_i(in_if.data[0]), .key_i(in_if.data[64:1]), .len_i(in_if.data[68:65]),
    .max_len_i(4'(KEY_BYTES_MAX)),
    .q_valid_o(qv), .q_ready_i(qr), .q_data_o(qd));

  lhte_back #(.EC(ENTRY_CAPACITY), .BS(BIN_SLOTS), .HW(HASH_WIDTH), .QW(QW)) u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_ready_o(qr), .q_data_i(qd),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .status_o(st), .index_o(ix), .count_o(cnt), .clearing_o(clr));

  assign out_if.data = {cnt, ix, st};
endmodule
`default_nettype wire

>>> design/lhte_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lhte_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);
  logic [W-1:0] mem_q [D];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> design/lhte_front.sv
// Front end: clamps length, masks key, hashes one byte per cycle, then pushes
// {cmd, len, key, hash} into a two-entry queue. Depends on lhte_pkg.
`default_nettype none
module lhte_front #(
  parameter int HW = 32,
  parameter int QW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          cmd_i,
  input  wire logic [63:0]   key_i,
  input  wire logic [3:0]    len_i,
  input  wire logic [3:0]    max_len_i,
  output logic               q_valid_o,
  input  wire logic          q_ready_i,
  output logic [QW-1:0]      q_data_o
);
  logic          busy_q, busy_d;
  logic [3:0]    cnt_q, cnt_d, len_q, len_d, len_c;
  logic [63:0]   key_q, key_d, key_c;
  logic          cmd_q, cmd_d;
  logic [HW-1:0] h_q, h_d;
  logic [QW-1:0] fifo_q [2];
  logic          rp_q, wp_q;
  logic [1:0]    fill_q;
  logic          push, pop;
  logic [7:0]    byte_c;

  always_comb begin
    len_c = (len_i == 4'd0) ? 4'd1 : len_i;
    if (len_c > max_len_i) len_c = max_len_i;
    key_c = key_i;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) >= len_c) key_c[b*8 +: 8] = 8'd0;
    end
  end

  assign in_ready_o = !busy_q;
  assign byte_c = key_q[{cnt_q[2:0], 3'b000} +: 8];
  assign push = busy_q && (cnt_q == len_q) && (fill_q != 2'd2);
  assign pop = q_valid_o && q_ready_i;

  // hashing sequencer
  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; len_d = len_q; key_d = key_q;
    cmd_d = cmd_q; h_d = h_q;
    if (!busy_q && in_valid_i) begin
      busy_d = 1'b1; cnt_d = 4'd0; len_d = len_c; key_d = key_c; cmd_d = cmd_i;
      h_d = HW'(lhte_pkg::HashSeed);
    end else if (busy_q && cnt_q != len_q) begin
      h_d = (h_q << 5) + h_q + HW'(byte_c);
      cnt_d = cnt_q + 4'd1;
    end else if (push) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; rp_q <= 1'b0; wp_q <= 1'b0; fill_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d; key_q <= key_d; cmd_q <= cmd_d; h_q <= h_d;
    if (push) fifo_q[wp_q] <= QW'({cmd_q, len_q, key_q, h_q});
  end

  assign q_valid_o = fill_q != 2'd0;
  assign q_data_o = fifo_q[rp_q];
endmodule
`default_nettype wire

>>> design/lhte_back.sv
// Back end: chain walk, insert and bin split over RAMs. Output register.
// Depends on lhte_pkg and lhte_ram.
`default_nettype none
module lhte_back #(
  parameter int EC = 256,
  parameter int BS = 512,
  parameter int HW = 32,
  parameter int QW = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  output logic             q_ready_o,
  input  wire logic [QW-1:0] q_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [7:0]       index_o,
  output logic [8:0]       count_o,
  output logic             clearing_o
);
  localparam int EW = $clog2(EC);
  localparam int PW = EW + 1;
  localparam int BW = $clog2(BS);
  localparam int CW = BW + 1;
  localparam logic [PW-1:0] Empty = PW'(EC);

  localparam logic [3:0] SClr = 4'd0, SIdle = 4'd1, SHead = 4'd2, SEnt = 4'd3,
    SCmp = 4'd4, SIns = 4'd5, SGrow = 4'd6, SSplH = 4'd7, SSplE = 4'd8,
    SSplW = 4'd9, SOut = 4'd10, SHeadW = 4'd11, SSplR = 4'd12;

  logic [3:0] st_q, st_d;
  logic          cmd_q;
  logic [3:0]    len_q;
  logic [63:0]   key_q;
  logic [HW-1:0] h_q;
  logic [BW-1:0] bin_q, clr_q, src_q, dst_q;
  logic [PW-1:0] cur_q, head_j_q, head_i_q;
  logic [CW-1:0] bcnt_q;
  logic [BW-1:0] full_q, front_q;
  logic [PW-1:0] used_q;
  logic [PW-1:0] guard_q;
  logic [1:0]    rst_st_q;
  logic [EW-1:0] ridx_q;
  logic          ov_q;

  // RAM ports
  logic          h_we, e_we, n_we;
  logic [BW-1:0] h_wa, h_ra;
  logic [PW-1:0] h_wd, h_rd;
  logic [EW-1:0] e_wa, e_ra, n_wa;
  logic [PW-1:0] n_wd, n_rd;
  logic [HW+4+64-1:0] e_wd, e_rd;

  lhte_ram #(.W(PW), .D(BS)) u_head (.clk_i, .we_i(h_we), .waddr_i(h_wa),
    .wdata_i(h_wd), .raddr_i(h_ra), .rdata_o(h_rd));
  lhte_ram #(.W(HW+68), .D(EC)) u_ent (.clk_i, .we_i(e_we), .waddr_i(e_wa),
    .wdata_i(e_wd), .raddr_i(e_ra), .rdata_o(e_rd));
  lhte_ram #(.W(PW), .D(EC)) u_next (.clk_i, .we_i(n_we), .waddr_i(n_wa),
    .wdata_i(n_wd), .raddr_i(e_ra), .rdata_o(n_rd));

  logic [BW-1:0] bin_c, move, src_c;
  logic [HW-1:0] qh;
  logic          hit, grow_ok, widen;
  assign qh = q_data_i[HW-1:0];
  always_comb begin
    bin_c = qh[BW-1:0] & full_q;
    if ({1'b0, bin_c} >= bcnt_q) bin_c = bin_c & front_q;
  end
  assign move = front_q ^ full_q;
  assign hit = e_rd == {h_q, len_q, key_q};
  assign widen = bcnt_q > {1'b0, full_q};
  assign grow_ok = (bcnt_q < CW'(BS)) &&
                   (!widen || ({1'b0, full_q, 1'b1} < CW'(BS)));
  // front bin to split, under the masks after growth
  assign src_c = bcnt_q[BW-1:0] & (widen ? full_q : front_q);
  assign q_ready_o = st_q == SIdle;
  assign clearing_o = st_q == SClr;

  always_comb begin
    h_we = 1'b0; h_wa = '0; h_wd = Empty; h_ra = bin_q;
    e_we = 1'b0; e_wa = used_q[EW-1:0]; e_wd = {h_q, len_q, key_q};
    e_ra = cur_q[EW-1:0]; n_we = 1'b0; n_wa = cur_q[EW-1:0]; n_wd = '0;
    st_d = st_q;
    unique case (st_q)
      SClr: begin
        h_we = 1'b1; h_wa = clr_q;
        if (clr_q == BW'(BS - 1)) st_d = SIdle;
      end
      SIdle: if (q_valid_i) st_d = SHead;
      SHead: st_d = SHeadW;
      SHeadW: st_d = (h_rd >= Empty) ? SIns : SEnt;
      SEnt: st_d = SCmp;
      SCmp: begin
        if (hit) st_d = SOut;
        else if (n_rd >= Empty || guard_q >= PW'(EC - 1)) st_d = SIns;
        else st_d = SEnt;
      end
      SIns: begin
        if (cmd_q == lhte_pkg::CmdInsert && used_q < Empty) begin
          e_we = 1'b1; n_we = 1'b1; n_wa = used_q[EW-1:0]; n_wd = head_j_q;
          h_we = 1'b1; h_wa = bin_q; h_wd = used_q;
          st_d = grow_ok ? SGrow : SOut;
        end else st_d = SOut;
      end
      SGrow: begin h_ra = src_c; st_d = SSplH; end
      SSplH: begin
        h_we = 1'b1; h_wa = dst_q;
        st_d = SSplR;
      end
      SSplR: begin
        h_we = 1'b1; h_wa = src_q;
        st_d = (cur_q >= Empty) ? SOut : SSplE;
      end
      SSplE: st_d = SSplW;
      SSplW: begin
        n_we = 1'b1; n_wa = cur_q[EW-1:0];
        if (|(e_rd[HW+67:68] & HW'(move))) begin
          n_wd = head_j_q; h_we = 1'b1; h_wa = dst_q; h_wd = cur_q;
        end else begin
          n_wd = head_i_q; h_we = 1'b1; h_wa = src_q; h_wd = cur_q;
        end
        st_d = (n_rd >= Empty || guard_q >= PW'(EC - 1)) ? SOut : SSplE;
      end
      SOut: if (!ov_q || out_ready_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClr; clr_q <= '0; ov_q <= 1'b0; bcnt_q <= CW'(1);
      full_q <= BW'(1); front_q <= '0; used_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == SClr) clr_q <= clr_q + BW'(1);
      if (out_valid_o && out_ready_i) ov_q <= 1'b0;
      if (st_q == SOut && st_d == SIdle) ov_q <= 1'b1;
      if (st_q == SIns && st_d != SOut || (st_q == SIns && st_d == SOut &&
          cmd_q == lhte_pkg::CmdInsert && used_q < Empty))
        used_q <= used_q + PW'(1);
      if (st_q == SGrow) begin
        bcnt_q <= bcnt_q + CW'(1);
        if (widen) begin front_q <= full_q; full_q <= {full_q[BW-2:0], 1'b1}; end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      SIdle: begin
        {cmd_q, len_q, key_q} <= q_data_i[QW-1:HW];
        h_q <= qh; bin_q <= bin_c; rst_st_q <= lhte_pkg::StNotFound;
        ridx_q <= '0; guard_q <= '0;
      end
      SHeadW: begin cur_q <= h_rd; head_j_q <= h_rd; end
      SCmp: begin
        if (hit) begin rst_st_q <= lhte_pkg::StFound; ridx_q <= cur_q[EW-1:0]; end
        cur_q <= n_rd; guard_q <= guard_q + PW'(1);
      end
      SIns: if (cmd_q == lhte_pkg::CmdInsert) begin
        if (used_q < Empty) begin
          rst_st_q <= lhte_pkg::StInserted; ridx_q <= used_q[EW-1:0];
        end else rst_st_q <= lhte_pkg::StFull;
      end
      SGrow: begin
        dst_q <= bcnt_q[BW-1:0];
        src_q <= src_c;
        guard_q <= '0;
      end
      SSplH: begin cur_q <= h_rd; head_j_q <= Empty; head_i_q <= Empty; end
      SSplW: begin
        if (|(e_rd[HW+67:68] & HW'(move))) head_j_q <= cur_q;
        else head_i_q <= cur_q;
        cur_q <= n_rd; guard_q <= guard_q + PW'(1);
      end
      // load the output only once the previous result has gone
      SOut: if (!ov_q || out_ready_i) begin
        status_o <= rst_st_q; index_o <= 8'(ridx_q); count_o <= 9'(used_q);
      end
      default: ;
    endcase
  end

  assign out_valid_o = ov_q;
endmodule
`default_nettype wire
